FILE: rtl/core/crsb_pkg.sv
// shared constants and types for the circle row span pipeline
package crsb_pkg;

  localparam int RADIUS_BITS_DEF = 9;
  localparam int ROW_W           = 9;

  // control that travels alongside each item through the pipeline
  typedef struct packed {
    logic valid;
    logic ok;
  } crsb_ctl_t;

endpackage

FILE: rtl/core/circle_row_span_bounds.sv
// Filled-circle row span generator. Takes one row offset per clock and, once the row has passed
// the pipeline, pulses done with the span of that row: left_x = r+1-ceil(s), right_x = r+1+floor(s),
// s = sqrt(2rh-h^2), for the upper row top_y = h and the mirrored row bottom_y = 2r+1-h.
// busy is always low; a new row may be started every cycle and the results come out in order,
// one per cycle, with no way to hold them off. The pipeline holds an input stage, a multiply
// stage, the square root, which resolves one root bit per pipeline stage, and an output stage.
// Rows of 0 or above the radius give row_ok low and all other fields zero. The user must write
// the radius through radius_we/radius only while no row is in flight; the block does not check.
module circle_row_span_bounds #(
  parameter int RADIUS_BITS = crsb_pkg::RADIUS_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         radius_we,
  input  logic [RADIUS_BITS-1:0]       radius,
  input  logic                         start,
  output logic                         busy,
  input  logic [crsb_pkg::ROW_W-1:0]   row,
  output logic                         done,
  output logic [RADIUS_BITS:0]         left_x,
  output logic [RADIUS_BITS:0]         right_x,
  output logic [crsb_pkg::ROW_W-1:0]   top_y,
  output logic [RADIUS_BITS:0]         bottom_y,
  output logic                         row_ok
);

  localparam int RB  = RADIUS_BITS;
  localparam int HW  = crsb_pkg::ROW_W;
  localparam int QW  = 2 * RB;
  localparam int W2  = RB + HW + 1;
  localparam int PW  = (QW > W2) ? QW : W2;
  localparam int LAT = RB + 3;

  logic [RB-1:0] rad;

  // stage 1: range check and 2r-h
  crsb_pkg::crsb_ctl_t s1_ctl;
  logic [HW-1:0]       s1_h;
  logic [RB:0]         s1_d;
  logic [W2-1:0]       d_wide;

  // stage 2: radicand
  crsb_pkg::crsb_ctl_t s2_ctl;
  logic [HW-1:0]       s2_h;
  logic [QW-1:0]       s2_q;
  logic [PW-1:0]       prod;

  // square root chain
  crsb_pkg::crsb_ctl_t ctl_a  [0:RB];
  logic [HW-1:0]       h_a    [0:RB];
  logic [QW-1:0]       q_a    [0:RB];
  logic [RB+1:0]       rem_a  [0:RB];
  logic [RB-1:0]       root_a [0:RB];

  // output stage
  logic [RB:0]   r_plus1;
  logic [RB:0]   fl;
  logic [RB:0]   cl;
  logic [W2-1:0] bot_wide;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rad <= RB'(1);
    end else if (radius_we) begin
      rad <= radius;
    end
  end

  assign d_wide = W2'({rad, 1'b0}) - W2'(row);

  assign prod = PW'(s1_h) * PW'(s1_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
      s2_ctl.valid <= 1'b0;
    end else begin
      s1_ctl.valid <= start && !busy;
      s2_ctl.valid <= s1_ctl.valid;
    end
    s1_ctl.ok <= (row != '0) && (W2'(row) <= W2'(rad));
    s1_h      <= row;
    s1_d      <= d_wide[RB:0];
    s2_ctl.ok <= s1_ctl.ok;
    s2_h      <= s1_h;
    s2_q      <= prod[QW-1:0];
  end

  assign ctl_a[0]  = s2_ctl;
  assign h_a[0]    = s2_h;
  assign q_a[0]    = s2_q;
  assign rem_a[0]  = '0;
  assign root_a[0] = '0;

  for (genvar i = 0; i < RB; i++) begin : g_sqrt
    crsb_sqrt_step #(
      .RADIUS_BITS (RB)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (ctl_a[i]),
      .h_in     (h_a[i]),
      .q_in     (q_a[i]),
      .rem_in   (rem_a[i]),
      .root_in  (root_a[i]),
      .ctl_out  (ctl_a[i+1]),
      .h_out    (h_a[i+1]),
      .q_out    (q_a[i+1]),
      .rem_out  (rem_a[i+1]),
      .root_out (root_a[i+1])
    );
  end

  // a nonzero remainder means the root was not exact, so ceil is one above floor
  assign r_plus1  = (RB+1)'(rad) + (RB+1)'(1);
  assign fl       = (RB+1)'(root_a[RB]);
  assign cl       = fl + (RB+1)'(rem_a[RB] != '0);
  assign bot_wide = W2'({rad, 1'b1}) - W2'(h_a[RB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_a[RB].valid;
    end
  end

  always_ff @(posedge clk) begin
    row_ok <= ctl_a[RB].ok;
    if (ctl_a[RB].ok) begin
      left_x   <= r_plus1 - cl;
      right_x  <= r_plus1 + fl;
      top_y    <= h_a[RB];
      bottom_y <= bot_wide[RB:0];
    end else begin
      left_x   <= '0;
      right_x  <= '0;
      top_y    <= '0;
      bottom_y <= '0;
    end
  end

`ifndef ASSERT_OFF
  // every started row pulses done once it has passed the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("started row did not complete after pipeline latency");

  // no result without a matching start
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a started row");

  // rejected rows carry zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    done && !row_ok |-> left_x == '0 && right_x == '0 && top_y == '0 && bottom_y == '0)
    else $error("out of range row with nonzero fields");

  // a valid span never runs backwards and keeps the row it was started with
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    done && row_ok |-> right_x >= left_x && top_y == $past(row, LAT))
    else $error("span edges out of order or row mismatch");
`endif

endmodule

FILE: rtl/core/crsb_sqrt_step.sv
// one registered stage of the integer square root, one root bit per stage
module crsb_sqrt_step #(
  parameter int RADIUS_BITS = crsb_pkg::RADIUS_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  crsb_pkg::crsb_ctl_t          ctl_in,
  input  logic [crsb_pkg::ROW_W-1:0]   h_in,
  input  logic [2*RADIUS_BITS-1:0]     q_in,
  input  logic [RADIUS_BITS+1:0]       rem_in,
  input  logic [RADIUS_BITS-1:0]       root_in,
  output crsb_pkg::crsb_ctl_t          ctl_out,
  output logic [crsb_pkg::ROW_W-1:0]   h_out,
  output logic [2*RADIUS_BITS-1:0]     q_out,
  output logic [RADIUS_BITS+1:0]       rem_out,
  output logic [RADIUS_BITS-1:0]       root_out
);

  localparam int RB = RADIUS_BITS;

  logic [RB+1:0] rem_sh;
  logic [RB+1:0] trial;
  logic          take;

  // bring down the next two radicand bits and try root*4+1
  assign rem_sh = {rem_in[RB-1:0], q_in[2*RB-1 -: 2]};
  assign trial  = {root_in, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.ok <= ctl_in.ok;
    h_out      <= h_in;
    q_out      <= {q_in[2*RB-3:0], 2'b00};
    rem_out    <= take ? (rem_sh - trial) : rem_sh;
    root_out   <= {root_in[RB-2:0], take};
  end

endmodule

FILE: tb/testbench.sv
// self-checking bench for the circle row span generator: rows against an in-bench span model
module testbench;

  localparam int RB      = crsb_pkg::RADIUS_BITS_DEF;
  localparam int RW      = crsb_pkg::ROW_W;
  localparam int LATENCY = RB + 3;
  localparam int LIMIT   = 200000;

  typedef struct packed {
    logic [RB:0]   left_x;
    logic [RB:0]   right_x;
    logic [RW-1:0] top_y;
    logic [RB:0]   bottom_y;
    logic          row_ok;
  } span_t;

  typedef enum logic [1:0] {ACT_ROW, ACT_SET_RADIUS, ACT_SET_PACE} act_t;

  typedef struct {
    act_t act;
    int   value;
  } plan_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          radius_we = 1'b0;
  logic [RB-1:0] radius_val = '0;
  logic          start = 1'b0;
  logic [RW-1:0] row = '0;
  logic          busy;
  logic          done;
  logic [RB:0]   left_x;
  logic [RB:0]   right_x;
  logic [RW-1:0] top_y;
  logic [RB:0]   bottom_y;
  logic          row_ok;

  plan_t         plan_q[$];
  span_t         span_q[$];
  logic [RB-1:0] cur_radius = RB'(1);
  int            idle_pct = 0;
  int            fails = 0;
  int            rows_sent = 0;
  int            rows_in_range = 0;
  int            radius_writes = 0;
  int            spans_checked = 0;
  int            cycles = 0;

  circle_row_span_bounds #(.RADIUS_BITS(RB)) DUT (
    .clk      (clk),
    .rst      (rst),
    .radius_we(radius_we),
    .radius   (radius_val),
    .start    (start),
    .busy     (busy),
    .row      (row),
    .done     (done),
    .left_x   (left_x),
    .right_x  (right_x),
    .top_y    (top_y),
    .bottom_y (bottom_y),
    .row_ok   (row_ok)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // exact span of row h on a circle of radius r
  function automatic span_t span_of(logic [RB-1:0] r, logic [RW-1:0] h);
    span_t       s;
    int unsigned ri, hi, q, root, trial, ceil_root;
    int          b;
    s = '0;
    ri = 32'(r);
    hi = 32'(h);
    if (hi == 0 || hi > ri) return s;
    q = hi * (2 * ri - hi);
    root = 0;
    for (b = RB; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= q) root = trial;
    end
    ceil_root = (root * root == q) ? root : root + 1;
    s.left_x   = (RB+1)'(ri + 1 - ceil_root);
    s.right_x  = (RB+1)'(ri + 1 + root);
    s.top_y    = h;
    s.bottom_y = (RB+1)'(2 * ri + 1 - hi);
    s.row_ok   = 1'b1;
    return s;
  endfunction

  task automatic add_row(int h);
    plan_q.push_back('{ACT_ROW, h});
  endtask

  task automatic add_radius(int r);
    plan_q.push_back('{ACT_SET_RADIUS, r});
  endtask

  task automatic add_pace(int pct);
    plan_q.push_back('{ACT_SET_PACE, pct});
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // driver: one transfer per cycle at most, radius writes only once the pipe is empty
  always @(posedge clk) begin : drive_proc
    plan_t cur;
    span_t want;
    logic  nxt_start;
    logic  nxt_we;
    if (rst) begin
      start     <= 1'b0;
      radius_we <= 1'b0;
    end else begin
      if (start && !busy) begin
        want = span_of(cur_radius, row);
        span_q.push_back(want);
        rows_sent++;
        if (want.row_ok) rows_in_range++;
      end
      nxt_start = start && busy;
      nxt_we    = 1'b0;
      if (!nxt_start) begin
        while (plan_q.size() > 0 && plan_q[0].act == ACT_SET_PACE) begin
          cur = plan_q.pop_front();
          idle_pct = cur.value;
        end
        if (plan_q.size() > 0) begin
          if (plan_q[0].act == ACT_SET_RADIUS) begin
            // hold off until every span in flight has come back
            if (span_q.size() == 0 && !start) begin
              cur = plan_q.pop_front();
              nxt_we = 1'b1;
              radius_val <= RB'(cur.value);
              cur_radius = RB'(cur.value);
              radius_writes++;
            end
          end else if ($urandom_range(99) >= idle_pct) begin
            cur = plan_q.pop_front();
            nxt_start = 1'b1;
            row <= RW'(cur.value);
          end
        end
      end
      start     <= nxt_start;
      radius_we <= nxt_we;
    end
  end

  always @(posedge clk) begin : check_proc
    span_t want;
    if (!rst && done) begin
      if (span_q.size() == 0) begin
        $error("span result with no row transfer pending");
        fails++;
      end else begin
        want = span_q.pop_front();
        check_field("left_x", int'(want.left_x), int'(left_x));
        check_field("right_x", int'(want.right_x), int'(right_x));
        check_field("top_y", int'(want.top_y), int'(top_y));
        check_field("bottom_y", int'(want.bottom_y), int'(bottom_y));
        check_field("row_ok", int'(want.row_ok), int'(row_ok));
        spans_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stim_proc
    int ph, k, sel, r, h;
    // reset radius is 1: empty row, the single row, and rows past it
    add_row(0);
    add_row(1);
    add_row(2);
    add_row(511);
    add_radius(511);
    add_row(1);
    add_row(255);
    add_row(256);
    add_row(510);
    add_row(511);
    add_row(0);
    // zero radius leaves no row in range
    add_radius(0);
    add_row(0);
    add_row(1);
    add_row(511);
    add_radius(2);
    add_row(1);
    add_row(2);
    add_row(3);
    // exact roots at h=5 and h=r, inexact elsewhere; h=r puts right edge at 2r+1
    add_radius(25);
    add_row(5);
    add_row(7);
    add_row(24);
    add_row(25);
    add_row(26);

    for (ph = 0; ph < 14; ph++) begin
      if (ph == 0) add_pace(8);
      if (ph == 5) add_pace(82);
      if (ph == 10) add_pace(0);
      if (ph == 3 || ph == 11) r = 511;
      else if (ph == 8) r = 1;
      else if (ph == 12) r = 0;
      else if (ph % 4 == 1) r = $urandom_range(8, 1);
      else r = $urandom_range(511, 1);
      add_radius(r);
      for (k = 0; k < 100; k++) begin
        sel = $urandom_range(99);
        if (r == 0 || sel < 10) h = $urandom_range(511);
        else if (sel < 16) begin
          case ($urandom_range(3))
            0: h = 0;
            1: h = 1;
            2: h = r;
            default: h = (r < 511) ? r + 1 : 511;
          endcase
        end else h = $urandom_range(r, 1);
        add_row(h);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (plan_q.size() != 0 || start || span_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (span_q.size() != 0) begin
      $error("%0d span results never arrived", span_q.size());
      fails++;
    end
    $display("checked %0d spans from %0d rows, %0d in range, over %0d radius writes",
             spans_checked, rows_sent, rows_in_range, radius_writes);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
